@@ src/relative_bearing_unit_assert.svh @@
// assertion helpers for the relative bearing unit
`ifndef RELATIVE_BEARING_UNIT_ASSERT_SVH
`define RELATIVE_BEARING_UNIT_ASSERT_SVH

// same-cycle implication, off while reset is held
`define RBU_ASSERT_NOW(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, off while reset is held
`define RBU_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

@@ src/rbu_pkg.sv @@
package rbu_pkg;

    localparam int CORDIC_STEPS = 16;
    localparam int ATAN_LEN     = 24;

    localparam int COORD_W = 32;
    localparam int DIFF_W  = COORD_W + 1;
    localparam int ANG_W   = 32;
    localparam int OUT_W   = 16;
    localparam int SCALE_W = 24;
    // rotated vector (DIFF_W + 1 bits) scaled by 2^24, plus headroom for cordic gain
    localparam int VEC_W   = DIFF_W + 1 + SCALE_W + 2;

    typedef logic signed [COORD_W-1:0] coord_t;
    typedef logic signed [DIFF_W-1:0]  diff_t;
    typedef logic signed [VEC_W-1:0]   vec_t;
    typedef logic [ANG_W-1:0]          bang_t;
    typedef logic signed [OUT_W-1:0]   angle_t;

    // atan(2^-i) in binary angle units, 2^32 = 2*pi
    localparam bang_t ATAN_TABLE [0:ATAN_LEN-1] = '{
        32'd536870912, 32'd316933406, 32'd167458907, 32'd85004756,
        32'd42667331,  32'd21354465,  32'd10679838,  32'd5340245,
        32'd2670163,   32'd1335087,   32'd667544,    32'd333772,
        32'd166886,    32'd83443,     32'd41722,     32'd20861,
        32'd10430,     32'd5215,      32'd2608,      32'd1304,
        32'd652,       32'd326,       32'd163,       32'd81
    };

    localparam bang_t  ANG_PLUS_QUARTER  = 32'h4000_0000;
    localparam bang_t  ANG_MINUS_QUARTER = 32'hC000_0000;
    localparam bang_t  ROUND_BIAS        = 32'h0000_8000;
    localparam angle_t OUT_PI            = 16'sh8000;

    localparam logic ACT_SIGHTING   = 1'b0;
    localparam logic ACT_TRAJECTORY = 1'b1;

endpackage

@@ src/rbu_if.sv @@
interface rbu_in_if;
    logic                 valid;
    logic                 ready;
    logic                 action;
    rbu_pkg::coord_t      a_x;
    rbu_pkg::coord_t      a_y;
    rbu_pkg::coord_t      b_x;
    rbu_pkg::coord_t      b_y;
    rbu_pkg::coord_t      ref_first;
    rbu_pkg::coord_t      ref_second;
    logic                 moving;

    modport source (
        output valid, action, a_x, a_y, b_x, b_y, ref_first, ref_second, moving,
        input  ready
    );
    modport sink (
        input  valid, action, a_x, a_y, b_x, b_y, ref_first, ref_second, moving,
        output ready
    );
endinterface

interface rbu_out_if;
    logic            valid;
    logic            ready;
    rbu_pkg::angle_t angle;

    modport source (
        output valid, angle,
        input  ready
    );
    modport sink (
        input  valid, angle,
        output ready
    );
endinterface

@@ src/rbu_cordic.sv @@
module rbu_cordic #(
    parameter int STEPS = rbu_pkg::CORDIC_STEPS
) (
    input  logic           clk,
    input  logic           en,
    input  rbu_pkg::diff_t y_in,
    input  rbu_pkg::diff_t x_in,
    output rbu_pkg::bang_t z_out
);

    localparam int EXT_W = rbu_pkg::DIFF_W + 1;
    localparam int PAD_W = rbu_pkg::VEC_W - EXT_W - rbu_pkg::SCALE_W;

    rbu_pkg::vec_t  x_reg    [0:STEPS];
    rbu_pkg::vec_t  y_reg    [0:STEPS];
    rbu_pkg::bang_t z_reg    [0:STEPS];
    logic           zero_reg [0:STEPS];

    logic signed [EXT_W-1:0] xe;
    logic signed [EXT_W-1:0] ye;
    logic signed [EXT_W-1:0] xr;
    logic signed [EXT_W-1:0] yr;
    rbu_pkg::vec_t           x_next;
    rbu_pkg::vec_t           y_next;
    rbu_pkg::bang_t          z_next;

    // left half-plane is turned by a quarter turn first
    always_comb
    begin
        xe = {x_in[rbu_pkg::DIFF_W-1], x_in};
        ye = {y_in[rbu_pkg::DIFF_W-1], y_in};
        xr = xe;
        yr = ye;
        z_next = '0;
        if (xe[EXT_W-1])
        begin
            if (!ye[EXT_W-1])
            begin
                xr = ye;
                yr = -xe;
                z_next = rbu_pkg::ANG_PLUS_QUARTER;
            end
            else
            begin
                xr = -ye;
                yr = xe;
                z_next = rbu_pkg::ANG_MINUS_QUARTER;
            end
        end
        x_next = {{PAD_W{xr[EXT_W-1]}}, xr, {rbu_pkg::SCALE_W{1'b0}}};
        y_next = {{PAD_W{yr[EXT_W-1]}}, yr, {rbu_pkg::SCALE_W{1'b0}}};
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            x_reg[0]    <= x_next;
            y_reg[0]    <= y_next;
            z_reg[0]    <= z_next;
            zero_reg[0] <= (x_in == '0) && (y_in == '0);
        end
    end

    for (genvar k = 0; k < STEPS; k++)
    begin : g_step
        rbu_pkg::vec_t  xs;
        rbu_pkg::vec_t  ys;
        rbu_pkg::vec_t  xs_next;
        rbu_pkg::vec_t  ys_next;
        rbu_pkg::bang_t zs_next;

        // arithmetic shift gives the floor
        always_comb
        begin
            xs = x_reg[k] >>> k;
            ys = y_reg[k] >>> k;
            if (!y_reg[k][rbu_pkg::VEC_W-1])
            begin
                xs_next = x_reg[k] + ys;
                ys_next = y_reg[k] - xs;
                zs_next = z_reg[k] + rbu_pkg::ATAN_TABLE[k];
            end
            else
            begin
                xs_next = x_reg[k] - ys;
                ys_next = y_reg[k] + xs;
                zs_next = z_reg[k] - rbu_pkg::ATAN_TABLE[k];
            end
        end

        always_ff @(posedge clk)
        begin
            if (en)
            begin
                x_reg[k+1]    <= xs_next;
                y_reg[k+1]    <= ys_next;
                z_reg[k+1]    <= zs_next;
                zero_reg[k+1] <= zero_reg[k];
            end
        end
    end

    assign z_out = zero_reg[STEPS] ? '0 : z_reg[STEPS];

endmodule

@@ src/relative_bearing_unit.sv @@
// Relative bearing unit: two CORDIC atan2 pipelines run side by side, one on the
// offset from observer to target and one on the reference vector, and the two
// angles are then added (sighting) or subtracted (trajectory) and rounded to a
// 16-bit binary angle (pi for a static observer in trajectory mode). An item
// is taken every cycle while the result side keeps up; each item passes through
// one input stage, one quarter-turn stage, one stage per CORDIC step and one
// combine stage. A stalled result freezes the whole pipeline.
`include "relative_bearing_unit_assert.svh"

module relative_bearing_unit #(
    parameter int CORDIC_STEPS = rbu_pkg::CORDIC_STEPS
) (
    input  logic      clk,
    input  logic      rst_n,
    rbu_in_if.sink    item,
    rbu_out_if.source result
);

    localparam int DEPTH = CORDIC_STEPS + 3;
    localparam int SIDE  = CORDIC_STEPS + 2;

    logic [DEPTH-1:0]  valid_reg;
    logic [DEPTH-1:0]  valid_next;
    logic              step;

    rbu_pkg::diff_t    dx_reg;
    rbu_pkg::diff_t    dy_reg;
    rbu_pkg::diff_t    r1_reg;
    rbu_pkg::diff_t    r2_reg;
    logic [SIDE-1:0]   act_reg;
    logic [SIDE-1:0]   spec_reg;

    rbu_pkg::bang_t    bearing;
    rbu_pkg::bang_t    ref_ang;
    rbu_pkg::bang_t    total;
    rbu_pkg::bang_t    rounded;
    rbu_pkg::angle_t   angle_reg;
    rbu_pkg::angle_t   angle_next;
    logic              spec_out_reg;

    assign step       = !valid_reg[DEPTH-1] || result.ready;
    assign item.ready = step;
    assign valid_next = {valid_reg[DEPTH-2:0], item.valid};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= '0;
        end
        else if (step)
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (step)
        begin
            dx_reg   <= rbu_pkg::diff_t'(item.b_x) - rbu_pkg::diff_t'(item.a_x);
            dy_reg   <= rbu_pkg::diff_t'(item.b_y) - rbu_pkg::diff_t'(item.a_y);
            r1_reg   <= rbu_pkg::diff_t'(item.ref_first);
            r2_reg   <= rbu_pkg::diff_t'(item.ref_second);
            act_reg  <= {act_reg[SIDE-2:0], item.action};
            spec_reg <= {spec_reg[SIDE-2:0],
                         (item.action == rbu_pkg::ACT_TRAJECTORY) && !item.moving};
        end
    end

    rbu_cordic #(
        .STEPS (CORDIC_STEPS)
    ) u_bearing (
        .clk   (clk),
        .en    (step),
        .y_in  (dy_reg),
        .x_in  (dx_reg),
        .z_out (bearing)
    );

    rbu_cordic #(
        .STEPS (CORDIC_STEPS)
    ) u_reference (
        .clk   (clk),
        .en    (step),
        .y_in  (r1_reg),
        .x_in  (r2_reg),
        .z_out (ref_ang)
    );

    // angles wrap modulo a full turn, then round to the nearest 16-bit step
    always_comb
    begin
        if (act_reg[SIDE-1] == rbu_pkg::ACT_TRAJECTORY)
        begin
            total = bearing - ref_ang;
        end
        else
        begin
            total = bearing + ref_ang;
        end
        rounded = total + rbu_pkg::ROUND_BIAS;
        if (spec_reg[SIDE-1])
        begin
            angle_next = rbu_pkg::OUT_PI;
        end
        else
        begin
            angle_next = rbu_pkg::angle_t'(rounded[rbu_pkg::ANG_W-1 -: rbu_pkg::OUT_W]);
        end
    end

    always_ff @(posedge clk)
    begin
        if (step)
        begin
            angle_reg    <= angle_next;
            spec_out_reg <= spec_reg[SIDE-1];
        end
    end

    assign result.valid = valid_reg[DEPTH-1];
    assign result.angle = angle_reg;

    `RBU_ASSERT_NOW(a_static_gives_pi, clk, rst_n, valid_reg[DEPTH-1] && spec_out_reg, angle_reg == rbu_pkg::OUT_PI, "static observer in trajectory mode did not give pi")
    `RBU_ASSERT_NEXT(a_stall_freezes_pipe, clk, rst_n, !step, valid_reg == $past(valid_reg), "pipeline moved while the result was stalled")

endmodule
